/* hdl/mlfq_pkg.sv */
// Shared types and constants for the multilevel feedback queue scheduler.
`default_nettype none
package mlfq_pkg;
  localparam logic [2:0] KIND_REQUEUE = 3'd0;
  localparam logic [2:0] KIND_EXIT    = 3'd1;
  localparam logic [2:0] KIND_BOOST   = 3'd2;
  localparam logic [2:0] KIND_ADMIT   = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;
  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_RUN   = 1'b1;
  localparam logic REG_QUEUE_LEVELS = 1'b0;
  localparam logic REG_BOOST_PERIOD = 1'b1;
  localparam logic [3:0] RESET_LEVELS = 4'd3;
  localparam logic [15:0] RESET_PERIOD = 16'd100;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] proc_id;
    logic [3:0] new_level;
    logic       last;
  } result_t;
endpackage
`default_nettype wire

/* hdl/mlfq_link_ram.sv */
// Next-link memory of the queued process lists, registered read.
`default_nettype none
module mlfq_link_ram #(
  parameter int Depth = 16,
  parameter int AW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [AW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [AW-1:0] rdata_o
);
  logic [AW-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/mlfq_scheduler_top.sv */
// Top level of the multilevel feedback queue scheduler.
//  channel  | dir | signals                         | content
//  s_axis   | in  | tvalid tready tdata tuser       | tdata: pid, demote_steps, finished; tuser: command
//  m_axis   | out | tvalid tready tdata tuser tlast | tdata: proc_id, new_level; tuser: kind
//  cfg      | in  | valid ready index data          | 0 queue_levels, 1 boost_period
// An admit or a rejected command is answered from the idle state. A run seeks a
// non-empty queue level by level, dispatches its head, and seeks again after the
// dispatch. A boost moves each process with a pop and a link read, paced
// by the link memory read port. Each result waits in the output register until
// taken; the engine stalls while it is full. A pending config write holds input.
// Reset empties all queues at once (valid bits only).
`default_nettype none
module mlfq_scheduler_top
  import mlfq_pkg::*;
#(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_LEVELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // pid[3:0], demote_steps[6:4], finished[7]
  input  wire logic        s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // proc_id[3:0], new_level[7:4]
  output logic [2:0]       m_axis_tuser,   // kind
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int LW = $clog2(MAX_LEVELS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int RstTop = (int'(RESET_LEVELS) > MAX_LEVELS) ? MAX_LEVELS - 1 :
                          int'(RESET_LEVELS) - 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_FIND = 7'b0000010, S_BPOP = 7'b0000100,
    S_BLNK = 7'b0001000, S_DISP = 7'b0010000, S_DLNK = 7'b0100000,
    S_POST = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [3:0]      qlev_q;
  logic [15:0]     period_q;
  logic [PW-1:0]   head_q [MAX_LEVELS];
  logic [PW-1:0]   tail_q [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] ne_q;
  logic [MAX_PROCS-1:0]  queued_q;
  logic [LW-1:0]   cur_q, blv_q;
  logic [15:0]     disp_q;
  logic [CW-1:0]   act_q;
  logic [LW:0]     cnt_q;
  logic [2:0]      dem_q;
  logic            fin_q, boosted_q;
  logic [PW-1:0]   pop_q;
  result_t         out_q;
  logic            ovalid_q;

  logic [LW-1:0] top;
  always_comb begin
    if (qlev_q == 4'd0) top = '0;
    else if (32'(qlev_q) > MAX_LEVELS) top = LW'(MAX_LEVELS - 1);
    else top = LW'(qlev_q - 4'd1);
  end

  function automatic logic [LW-1:0] step_dn(input logic [LW-1:0] lv, input logic [LW-1:0] t);
    return (lv == '0) ? t : lv - LW'(1);
  endfunction

  logic          lk_we;
  logic [PW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;
  mlfq_link_ram #(.Depth(MAX_PROCS), .AW(PW)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd),
    .raddr_i(lk_ra), .rdata_o(lk_rd)
  );

  logic oslot;
  assign oslot = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && oslot && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {out_q.new_level, out_q.proc_id};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  logic [LW-1:0] nl;
  logic [LW:0]   lvx;
  assign lvx = {1'b0, blv_q};
  assign nl = ({1'b0, dem_q} >= 4'(lvx)) ? '0 : LW'(4'(lvx) - {1'b0, dem_q});

  always_comb begin
    state_d = state_q;
    lk_ra = head_q[blv_q];
    case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_RUN && act_q != '0)
                state_d = S_FIND;
      S_FIND: if (ne_q[cur_q] || cnt_q > {1'b0, top}) state_d = S_POST;
      S_BPOP: if (oslot) state_d = S_BLNK;
      S_DISP: if (oslot) state_d = S_DLNK;
      default: ;
    endcase
  end

  logic ipk, rgo;
  logic [PW-1:0] ppid;
  assign ppid = PW'(s_axis_tdata[3:0]);
  assign ipk = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; qlev_q <= RESET_LEVELS; period_q <= RESET_PERIOD;
      ne_q <= '0; queued_q <= '0; cur_q <= LW'(RstTop);
      disp_q <= '0; act_q <= '0; ovalid_q <= 1'b0; cnt_q <= '0;
      boosted_q <= 1'b0; blv_q <= '0; lk_we <= 1'b0;
    end else begin
      lk_we <= 1'b0;
      if (m_axis_tready) ovalid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_QUEUE_LEVELS) begin
          qlev_q <= cfg_data_i[3:0]; ne_q <= '0; queued_q <= '0;
          disp_q <= '0; act_q <= '0;
          if (cfg_data_i[3:0] == 4'd0) cur_q <= '0;
          else if (32'(cfg_data_i[3:0]) > MAX_LEVELS) cur_q <= LW'(MAX_LEVELS - 1);
          else cur_q <= LW'(cfg_data_i[3:0] - 4'd1);
        end else period_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: if (ipk) begin
          dem_q <= s_axis_tdata[6:4]; fin_q <= s_axis_tdata[7];
          cnt_q <= '0; boosted_q <= 1'b0; ovalid_q <= 1'b1;
          if (s_axis_tuser == CMD_ADMIT) begin
            if (32'(s_axis_tdata[3:0]) >= MAX_PROCS || queued_q[ppid] ||
                32'(act_q) >= MAX_PROCS) begin
              out_q <= '{KIND_ERROR, s_axis_tdata[3:0], 4'd0, 1'b1};
            end else begin
              if (ne_q[top]) begin lk_we <= 1'b1; lk_wa <= tail_q[top]; lk_wd <= ppid; end
              else head_q[top] <= ppid;
              tail_q[top] <= ppid; ne_q[top] <= 1'b1;
              queued_q[ppid] <= 1'b1; act_q <= act_q + CW'(1);
              out_q <= '{KIND_ADMIT, s_axis_tdata[3:0], 4'(top) + 4'd1, 1'b1};
            end
          end else if (act_q == '0) out_q <= '{KIND_ERROR, 4'd0, 4'd0, 1'b1};
          else ovalid_q <= 1'b0;
        end
        S_FIND: begin
          if (ne_q[cur_q] || cnt_q > {1'b0, top}) begin
            cnt_q <= '0;
            if (!boosted_q && disp_q >= period_q) begin
              boosted_q <= 1'b1; blv_q <= cur_q; state_q <= S_BPOP;
            end else begin
              blv_q <= cur_q; state_q <= boosted_q ? S_IDLE : S_DISP;
            end
            if (boosted_q) state_q <= S_IDLE;
          end else begin
            cur_q <= step_dn(cur_q, top); cnt_q <= cnt_q + 1'b1;
          end
          if (!(ne_q[cur_q] || cnt_q > {1'b0, top})) state_q <= S_FIND;
        end
        S_BPOP: begin
          if (cnt_q > {1'b0, top}) begin
            disp_q <= '0; cur_q <= top; blv_q <= top; state_q <= S_DISP;
          end else if (blv_q == top || !ne_q[blv_q]) begin
            blv_q <= step_dn(blv_q, top); cnt_q <= cnt_q + 1'b1;
          end else if (oslot) begin
            pop_q <= head_q[blv_q];
            if (ne_q[top]) begin lk_we <= 1'b1; lk_wa <= tail_q[top]; lk_wd <= head_q[blv_q]; end
            else head_q[top] <= head_q[blv_q];
            tail_q[top] <= head_q[blv_q]; ne_q[top] <= 1'b1;
            if (head_q[blv_q] == tail_q[blv_q]) ne_q[blv_q] <= 1'b0;
            ovalid_q <= 1'b1;
            out_q <= '{KIND_BOOST, 4'(head_q[blv_q]), 4'(top) + 4'd1, 1'b0};
            state_q <= S_BLNK;
          end
        end
        S_BLNK: begin
          if (ne_q[blv_q]) head_q[blv_q] <= lk_rd;
          state_q <= S_BPOP;
        end
        S_DISP: if (oslot) begin
          pop_q <= head_q[blv_q]; ovalid_q <= 1'b1;
          if (head_q[blv_q] == tail_q[blv_q]) ne_q[blv_q] <= 1'b0;
          state_q <= S_DLNK;
          if (fin_q) begin
            queued_q[head_q[blv_q]] <= 1'b0; act_q <= act_q - CW'(1);
            out_q <= '{KIND_EXIT, 4'(head_q[blv_q]), 4'd0, 1'b1};
          end else
            out_q <= '{KIND_REQUEUE, 4'(head_q[blv_q]), 4'(nl) + 4'd1, 1'b1};
        end
        S_DLNK: begin
          if (ne_q[blv_q]) head_q[blv_q] <= lk_rd;
          if (!fin_q) begin
            if (ne_q[nl]) begin lk_we <= 1'b1; lk_wa <= tail_q[nl]; lk_wd <= pop_q; end
            else head_q[nl] <= pop_q;
            tail_q[nl] <= pop_q; ne_q[nl] <= 1'b1;
          end
          disp_q <= disp_q + 16'd1; cnt_q <= '0; boosted_q <= 1'b1;
          state_q <= S_FIND;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_IDLE && state_d == S_FIND) state_q <= S_FIND;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> ($stable(out_q) && ovalid_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(act_q) <= MAX_PROCS)
    else $error("active count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q == '0) |-> (ne_q == '0 || state_q != S_IDLE))
    else $error("queues not empty with no process");
endmodule
`default_nettype wire
